// ===== rtl/core/clm_pkg.sv =====
// ----------------------------------------------------------------------------
// clm_pkg - shared types and constants of the cursor linked list manager
// Slot geometry, command codes, controller states and datapath micro-ops.
// ----------------------------------------------------------------------------
package clm_pkg;

  localparam int CAPACITY  = 64;
  localparam int WORD_BITS = 32;
  localparam int SLOTS     = CAPACITY + 2;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CMD_W     = 3;
  localparam int FLD_W     = 7;
  localparam int IN_W      = ((CMD_W + FLD_W + WORD_BITS + 7) / 8) * 8;
  // status, read word, new position, entry count, full and empty flags
  localparam int OUT_RAW_W = 1 + WORD_BITS + 2 * FLD_W + 2;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;
  localparam logic [FLD_W-1:0] CAP_RESET = FLD_W'(64);

  // Slot numbers of the two list heads, the nil link and the first data slot
  localparam logic [SLOT_W-1:0] USED_HEAD = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] FREE_HEAD = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] NIL       = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] FIRST_DATA = SLOT_W'(2);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RETRIEVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REPLACE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

  typedef enum logic [1:0] {
    WALK_TAIL,
    WALK_PRED,
    WALK_FREE
  } walk_mode_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_WALK,
    ST_TAKE,
    ST_POP,
    ST_LINK_PRED,
    ST_SEL_SLOT,
    ST_UNLINK,
    ST_FREE_WALK,
    ST_LINK_SLOT,
    ST_LINK_F,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FAIL,
    OP_REPLACE,
    OP_CLR_START,
    OP_CLR_STEP,
    OP_WALK_TAIL,
    OP_WALK_PRED,
    OP_WALK_STEP,
    OP_TAKE,
    OP_POP,
    OP_LINK_PRED,
    OP_SEL_SLOT,
    OP_UNLINK,
    OP_LINK_SLOT,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             occ;
    logic             full;
    logic             walk_stop;
    logic             sweep_done;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/clm_ctrl.sv =====
// ----------------------------------------------------------------------------
// clm_ctrl - command sequencer
// Steps each command through its micro-ops and drives the input handshake.
// ----------------------------------------------------------------------------
module clm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  clm_pkg::dp_stat_t stat,
  output clm_pkg::dp_op_t   op
);

  clm_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clm_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      clm_pkg::ST_INIT: begin
        if (stat.sweep_done) state_nxt = clm_pkg::ST_IDLE;
      end
      clm_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = clm_pkg::ST_DECODE;
      end
      clm_pkg::ST_DECODE: begin
        case (stat.cmd)
          clm_pkg::CMD_APPEND: begin
            state_nxt = stat.full ? clm_pkg::ST_DONE : clm_pkg::ST_WALK;
          end
          clm_pkg::CMD_INSERT: begin
            state_nxt = (stat.occ && !stat.full) ? clm_pkg::ST_WALK : clm_pkg::ST_DONE;
          end
          clm_pkg::CMD_REMOVE: begin
            state_nxt = stat.occ ? clm_pkg::ST_WALK : clm_pkg::ST_DONE;
          end
          clm_pkg::CMD_CLEAR: begin
            state_nxt = clm_pkg::ST_CLEAR;
          end
          default: begin
            state_nxt = clm_pkg::ST_DONE;
          end
        endcase
      end
      clm_pkg::ST_CLEAR: begin
        if (stat.sweep_done) state_nxt = clm_pkg::ST_DONE;
      end
      clm_pkg::ST_WALK: begin
        if (stat.walk_stop) begin
          state_nxt = (stat.cmd == clm_pkg::CMD_REMOVE) ? clm_pkg::ST_SEL_SLOT
                                                        : clm_pkg::ST_TAKE;
        end
      end
      clm_pkg::ST_TAKE:      state_nxt = clm_pkg::ST_POP;
      clm_pkg::ST_POP:       state_nxt = clm_pkg::ST_LINK_PRED;
      clm_pkg::ST_LINK_PRED: state_nxt = clm_pkg::ST_DONE;
      clm_pkg::ST_SEL_SLOT:  state_nxt = clm_pkg::ST_UNLINK;
      clm_pkg::ST_UNLINK:    state_nxt = clm_pkg::ST_FREE_WALK;
      clm_pkg::ST_FREE_WALK: begin
        if (stat.walk_stop) state_nxt = clm_pkg::ST_LINK_SLOT;
      end
      clm_pkg::ST_LINK_SLOT: state_nxt = clm_pkg::ST_LINK_F;
      clm_pkg::ST_LINK_F:    state_nxt = clm_pkg::ST_DONE;
      clm_pkg::ST_DONE: begin
        if (stat.out_free) state_nxt = clm_pkg::ST_IDLE;
      end
      default: state_nxt = clm_pkg::ST_INIT;
    endcase
  end

  // Micro-op per state
  always_comb begin
    op        = clm_pkg::OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      clm_pkg::ST_INIT, clm_pkg::ST_CLEAR: op = clm_pkg::OP_CLR_STEP;
      clm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) op = clm_pkg::OP_LOAD;
      end
      clm_pkg::ST_DECODE: begin
        case (stat.cmd)
          clm_pkg::CMD_APPEND: begin
            op = stat.full ? clm_pkg::OP_FAIL : clm_pkg::OP_WALK_TAIL;
          end
          clm_pkg::CMD_INSERT: begin
            op = (stat.occ && !stat.full) ? clm_pkg::OP_WALK_PRED : clm_pkg::OP_FAIL;
          end
          clm_pkg::CMD_REMOVE: begin
            op = stat.occ ? clm_pkg::OP_WALK_PRED : clm_pkg::OP_FAIL;
          end
          clm_pkg::CMD_RETRIEVE: begin
            op = stat.occ ? clm_pkg::OP_NONE : clm_pkg::OP_FAIL;
          end
          clm_pkg::CMD_REPLACE: begin
            op = stat.occ ? clm_pkg::OP_REPLACE : clm_pkg::OP_FAIL;
          end
          clm_pkg::CMD_CLEAR: op = clm_pkg::OP_CLR_START;
          default:            op = clm_pkg::OP_FAIL;
        endcase
      end
      clm_pkg::ST_WALK, clm_pkg::ST_FREE_WALK: op = clm_pkg::OP_WALK_STEP;
      clm_pkg::ST_TAKE:                        op = clm_pkg::OP_TAKE;
      clm_pkg::ST_POP:                         op = clm_pkg::OP_POP;
      clm_pkg::ST_LINK_PRED, clm_pkg::ST_LINK_F: op = clm_pkg::OP_LINK_PRED;
      clm_pkg::ST_SEL_SLOT:                    op = clm_pkg::OP_SEL_SLOT;
      clm_pkg::ST_UNLINK:                      op = clm_pkg::OP_UNLINK;
      clm_pkg::ST_LINK_SLOT:                   op = clm_pkg::OP_LINK_SLOT;
      clm_pkg::ST_DONE: begin
        if (stat.out_free) op = clm_pkg::OP_EMIT;
      end
      default: op = clm_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== rtl/core/clm_dp.sv =====
// ----------------------------------------------------------------------------
// clm_dp - list datapath
// Link and data memories, head pointers, walk cursor, valid marks, counters
// and the result register.
// ----------------------------------------------------------------------------
module clm_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  clm_pkg::dp_op_t                   op,
  output clm_pkg::dp_stat_t                 stat,
  input  logic                              cfg_wr_en,
  input  logic [clm_pkg::FLD_W-1:0]         cfg_wr_data,
  input  logic [clm_pkg::IN_W-1:0]          in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [clm_pkg::OUT_W-1:0]         out_tdata
);

  localparam int SW = clm_pkg::SLOT_W;
  localparam int WB = clm_pkg::WORD_BITS;
  localparam int CW = clm_pkg::CMD_W;
  localparam int FW = clm_pkg::FLD_W;

  // Storage
  logic [SW-1:0] link_mem [clm_pkg::SLOTS];
  logic [WB-1:0] data_mem [clm_pkg::SLOTS];
  logic [clm_pkg::SLOTS-1:0] valid_r;

  // Control state
  logic [FW-1:0] cfg_cap_r;
  logic [FW-1:0] active_cap_r;
  logic [SW-1:0] used_head_r, free_head_r;
  logic [FW-1:0] count_r;
  logic [SW-1:0] sweep_r;
  logic          out_valid_r;

  // Item and walk registers
  logic [CW-1:0] cmd_r;
  logic [SW-1:0] slot_r;
  logic [FW-1:0] pos_r;
  logic [WB-1:0] val_r;
  logic          ok_r;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [SW-1:0] pred_r, j_r, lk_r;
  clm_pkg::walk_mode_t mode_r;
  logic [FW-1:0] newpos_r;
  logic [SW-1:0] link_rd_r;
  logic [WB-1:0] data_rd_r;
  logic [clm_pkg::OUT_RAW_W-1:0] out_r;

  // Combinational helpers
  logic [SW-1:0] lk;
  logic          stop;
  logic          pos_ok, occ;
  logic [FW-1:0] cap_clamped;
  logic          lw_en;
  logic [SW-1:0] lw_addr, lw_val;
  logic          dw_en;
  logic [SW-1:0] dw_addr;
  logic          sweep_done;
  logic [WB-1:0] rd_word;

  // Link of the cursor slot: heads live in registers
  always_comb begin
    if (cur_r == clm_pkg::USED_HEAD) begin
      lk = used_head_r;
    end else if (cur_r == clm_pkg::FREE_HEAD) begin
      lk = free_head_r;
    end else begin
      lk = link_rd_r;
    end
  end

  // Walk stop test
  always_comb begin
    case (mode_r)
      clm_pkg::WALK_TAIL: stop = (lk == clm_pkg::NIL);
      clm_pkg::WALK_PRED: stop = (lk == clm_pkg::NIL) || (lk == slot_r);
      clm_pkg::WALK_FREE: stop = (lk == clm_pkg::NIL) || (lk >= slot_r);
      default:            stop = 1'b1;
    endcase
  end

  // Position checks; bounds first, then occupancy
  assign pos_ok = (pos_r != '0) && (pos_r <= active_cap_r);
  assign occ    = pos_ok && valid_r[slot_r];

  always_comb begin
    if (cfg_cap_r == '0) begin
      cap_clamped = FW'(1);
    end else if (cfg_cap_r > FW'(clm_pkg::CAPACITY)) begin
      cap_clamped = FW'(clm_pkg::CAPACITY);
    end else begin
      cap_clamped = cfg_cap_r;
    end
  end

  assign sweep_done = (sweep_r == SW'(clm_pkg::SLOTS - 1));

  // Cursor next value; the link memory is always read at it
  always_comb begin
    cur_nxt = cur_r;
    case (op)
      clm_pkg::OP_WALK_TAIL, clm_pkg::OP_WALK_PRED: cur_nxt = clm_pkg::USED_HEAD;
      clm_pkg::OP_WALK_STEP: begin
        if (!stop) cur_nxt = lk;
      end
      clm_pkg::OP_TAKE:     cur_nxt = free_head_r;
      clm_pkg::OP_SEL_SLOT: cur_nxt = slot_r;
      clm_pkg::OP_UNLINK:   cur_nxt = clm_pkg::FREE_HEAD;
      default:              cur_nxt = cur_r;
    endcase
  end

  // Link write: target slot and new successor
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = pred_r;
    lw_val  = j_r;
    case (op)
      clm_pkg::OP_CLR_STEP: begin
        lw_en   = 1'b1;
        lw_addr = sweep_r;
        lw_val  = (FW'(sweep_r) <= active_cap_r) ? sweep_r + SW'(1) : clm_pkg::NIL;
      end
      clm_pkg::OP_POP: begin
        lw_en   = 1'b1;
        lw_addr = j_r;
        lw_val  = (cmd_r == clm_pkg::CMD_INSERT) ? slot_r : clm_pkg::NIL;
      end
      clm_pkg::OP_LINK_PRED: begin
        lw_en   = 1'b1;
        lw_addr = pred_r;
        lw_val  = (cmd_r == clm_pkg::CMD_REMOVE) ? slot_r : j_r;
      end
      clm_pkg::OP_UNLINK: begin
        lw_en   = 1'b1;
        lw_addr = pred_r;
        lw_val  = lk;
      end
      clm_pkg::OP_LINK_SLOT: begin
        lw_en   = 1'b1;
        lw_addr = slot_r;
        lw_val  = lk_r;
      end
      default: lw_en = 1'b0;
    endcase
  end

  // Data write by pop or replace
  assign dw_en   = (op == clm_pkg::OP_POP) || (op == clm_pkg::OP_REPLACE);
  assign dw_addr = (op == clm_pkg::OP_POP) ? j_r : slot_r;

  // Link memory
  always_ff @(posedge clk) begin
    if (lw_en && (lw_addr != clm_pkg::USED_HEAD) && (lw_addr != clm_pkg::FREE_HEAD)) begin
      link_mem[lw_addr] <= lw_val;
    end
    link_rd_r <= link_mem[cur_nxt];
  end

  // Data memory
  always_ff @(posedge clk) begin
    if (dw_en) begin
      data_mem[dw_addr] <= val_r;
    end
    data_rd_r <= data_mem[slot_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cap_r    <= clm_pkg::CAP_RESET;
      active_cap_r <= clm_pkg::CAP_RESET;
      used_head_r  <= clm_pkg::NIL;
      free_head_r  <= clm_pkg::FIRST_DATA;
      count_r      <= '0;
      valid_r      <= '0;
      sweep_r      <= clm_pkg::FIRST_DATA;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) cfg_cap_r <= cfg_wr_data;

      // head pointers follow link writes aimed at them
      if (lw_en && (lw_addr == clm_pkg::USED_HEAD)) used_head_r <= lw_val;
      if (lw_en && (lw_addr == clm_pkg::FREE_HEAD)) free_head_r <= lw_val;

      case (op)
        clm_pkg::OP_CLR_START: begin
          active_cap_r <= cap_clamped;
          used_head_r  <= clm_pkg::NIL;
          free_head_r  <= clm_pkg::FIRST_DATA;
          count_r      <= '0;
          valid_r      <= '0;
          sweep_r      <= clm_pkg::FIRST_DATA;
        end
        clm_pkg::OP_CLR_STEP: begin
          if (!sweep_done) sweep_r <= sweep_r + SW'(1);
        end
        clm_pkg::OP_POP: begin
          free_head_r  <= lk;
          valid_r[j_r] <= 1'b1;
          count_r      <= count_r + FW'(1);
        end
        clm_pkg::OP_UNLINK: begin
          valid_r[slot_r] <= 1'b0;
          if (count_r != '0) count_r <= count_r - FW'(1);
        end
        default: begin
        end
      endcase

      if (op == clm_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Returned word: retrieve and remove only
  assign rd_word = (ok_r && ((cmd_r == clm_pkg::CMD_RETRIEVE) ||
                   (cmd_r == clm_pkg::CMD_REMOVE))) ? data_rd_r : '0;

  // Item, walk and result registers
  always_ff @(posedge clk) begin
    if (op == clm_pkg::OP_LOAD) begin
      cmd_r    <= in_tdata[CW-1:0];
      pos_r    <= in_tdata[CW+FW-1:CW];
      slot_r   <= SW'(in_tdata[CW+FW-1:CW] + FW'(1));
      val_r    <= in_tdata[CW+FW+WB-1:CW+FW];
      ok_r     <= 1'b1;
      newpos_r <= '0;
    end
    if (op == clm_pkg::OP_FAIL) ok_r <= 1'b0;
    cur_r <= cur_nxt;
    case (op)
      clm_pkg::OP_WALK_TAIL: mode_r <= clm_pkg::WALK_TAIL;
      clm_pkg::OP_WALK_PRED: mode_r <= clm_pkg::WALK_PRED;
      clm_pkg::OP_UNLINK:    mode_r <= clm_pkg::WALK_FREE;
      clm_pkg::OP_WALK_STEP: begin
        if (stop) begin
          pred_r <= cur_r;
          lk_r   <= lk;
        end
      end
      clm_pkg::OP_TAKE: j_r      <= free_head_r;
      clm_pkg::OP_POP:  newpos_r <= FW'(j_r - SW'(1));
      default: begin
      end
    endcase
    if (op == clm_pkg::OP_EMIT) begin
      out_r <= {(used_head_r == clm_pkg::NIL), (free_head_r == clm_pkg::NIL),
                count_r, newpos_r, rd_word, !ok_r};
    end
  end

  // Status to the sequencer
  assign stat.cmd        = cmd_r;
  assign stat.occ        = occ;
  assign stat.full       = (free_head_r == clm_pkg::NIL);
  assign stat.walk_stop  = stop;
  assign stat.sweep_done = sweep_done;
  assign stat.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(clm_pkg::OUT_W - clm_pkg::OUT_RAW_W){1'b0}}, out_r};

`ifndef SYNTH
  // entry count never exceeds the active capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= active_cap_r)
    else $error("entry count above capacity");

  // occupied marks and entry count move together
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(count_r))
    else $error("valid marks disagree with entry count");

  // head slots never hold data
  a_heads_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[0] && !valid_r[1])
    else $error("head slot marked valid");

  // a finished walk leaves the slot it stopped on in pred_r
  a_walk_save: assert property (@(posedge clk) disable iff (!rst_n)
    (op == clm_pkg::OP_WALK_STEP && stop) |=> (pred_r == $past(cur_r)))
    else $error("walk result not captured");
`endif

endmodule

// ===== rtl/core/cursor_linked_list_manager_top.sv =====
// Append and insert walk the used chain, one link memory read a cycle; remove walks the
//   used chain then the free chain.
// Clear rebuilds one link memory entry per cycle.
// Throughput: one command at a time; the next is taken once the result is registered.
// Reset: synchronous active-low; a link rebuild follows with in_tready low.
// ----------------------------------------------------------------------------
// cursor_linked_list_manager_top - static linked list with free list
// Sequencer plus datapath over a fixed slot array, stream in and out.
// ----------------------------------------------------------------------------
module cursor_linked_list_manager_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [clm_pkg::FLD_W-1:0]     cfg_wr_data,   // used_capacity
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [clm_pkg::IN_W-1:0]      in_tdata,      // command, position, value
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [clm_pkg::OUT_W-1:0]     out_tdata      // status, read_value, new_position,
                                                       // entry_count, list_full, list_empty
);

  clm_pkg::dp_op_t   op;
  clm_pkg::dp_stat_t stat;

  // Sequencer
  clm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .op        (op)
  );

  // Datapath
  clm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
